@@ hdl/ssmv_pkg.sv @@
// Package for the sample set statistics block: widths, state codes and the
// command and status structs that join the controller to the datapath.
// No dependencies.
`default_nettype none

package ssmv_pkg;

  localparam int STORE_DEPTH = 64;

  // Fixed field widths of the channels.
  localparam int SMP_W      = 32;
  localparam int IN_IDX_W   = 7;
  localparam int TOT_W      = 38;
  localparam int MEAN_W     = 32;
  localparam int VAR_W      = 64;
  localparam int SD_W       = 32;
  localparam int OUT_CNT_W  = 7;
  localparam int STATUS_W   = 2;

  // Widths that follow from the store depth.
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CMP_W   = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
  localparam int ACC_W   = VAR_W + CNT_W;
  localparam int REM_W   = CNT_W + 1;
  localparam int DCNT_W  = $clog2(ACC_W + 1);

  localparam logic [VAR_W-1:0] SQ_BIT_INIT = {2'b01, {(VAR_W-2){1'b0}}};

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPD   = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_MDIV  = 8'b0000_1000,
    S_VPASS = 8'b0001_0000,
    S_VDIV  = 8'b0010_0000,
    S_SQRT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } ssmv_state_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic pass_start;
    logic pass_var;
    logic div_start;
    logic div_var;
    logic mean_take;
    logic sqrt_start;
    logic out_load;
  } ssmv_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic div_done;
    logic sqrt_done;
  } ssmv_stat_t;

endpackage

`default_nettype wire

@@ hdl/ssmv_if.sv @@
// Channel interfaces of the sample set statistics block: input item and
// result item, each with valid, ready and payload. Depends on ssmv_pkg.
`default_nettype none

interface ssmv_in_if import ssmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [IN_IDX_W-1:0]        entry_index;
  logic signed [SMP_W-1:0]    sample;

  modport source(output valid, mode, entry_index, sample, input ready);
  modport sink(input valid, mode, entry_index, sample, output ready);
endinterface

interface ssmv_out_if import ssmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TOT_W-1:0]    sample_total;
  logic signed [MEAN_W-1:0]   sample_mean;
  logic [VAR_W-1:0]           sample_variance;
  logic [SD_W-1:0]            std_deviation;
  logic [OUT_CNT_W-1:0]       stored_count;
  logic [STATUS_W-1:0]        status;

  modport source(output valid, sample_total, sample_mean, sample_variance,
                 std_deviation, stored_count, status, input ready);
  modport sink(input valid, sample_total, sample_mean, sample_variance,
               std_deviation, stored_count, status, output ready);
endinterface

`default_nettype wire

@@ hdl/ssmv_ctrl.sv @@
// Controller of the sample set statistics block: sequences the update, the
// two passes, the two divides and the square root. Depends on ssmv_pkg.
`default_nettype none

module ssmv_ctrl import ssmv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ssmv_stat_t stat,
  output ssmv_cmd_t  cmd
);

  ssmv_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd        = 1'b1;
        cmd.pass_start = 1'b1;
        state_nxt      = S_SUM;
      end
      S_SUM: begin
        if (stat.pass_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_MDIV;
        end
      end
      S_MDIV: begin
        if (stat.div_done) begin
          cmd.mean_take  = 1'b1;
          cmd.pass_start = 1'b1;
          cmd.pass_var   = 1'b1;
          state_nxt      = S_VPASS;
        end
      end
      S_VPASS: begin
        if (stat.pass_done) begin
          cmd.div_start = 1'b1;
          cmd.div_var   = 1'b1;
          state_nxt     = S_VDIV;
        end
      end
      S_VDIV: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // The previous result must have been taken before it is replaced.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_UPD)
    else $error("item taken outside idle");

  a_out_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> $past(state_r) == S_SQRT || $past(state_r) == S_OUT)
    else $error("result stage entered out of order");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("pending result dropped");

endmodule

`default_nettype wire

@@ hdl/ssmv_dp.sv @@
// Datapath of the sample set statistics block: sample store, sum and
// squared deviation passes, shared serial divider, serial square root and
// the result register. Depends on ssmv_pkg.
`default_nettype none

module ssmv_dp import ssmv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ssmv_cmd_t                cmd,
  output ssmv_stat_t               stat,
  input  logic                     in_mode,
  input  logic [IN_IDX_W-1:0]      in_entry_index,
  input  logic signed [SMP_W-1:0]  in_sample,
  output logic signed [TOT_W-1:0]  out_sample_total,
  output logic signed [MEAN_W-1:0] out_sample_mean,
  output logic [VAR_W-1:0]         out_sample_variance,
  output logic [SD_W-1:0]          out_std_deviation,
  output logic [OUT_CNT_W-1:0]     out_stored_count,
  output logic [STATUS_W-1:0]      out_status
);

  // Latched item.
  logic                    mode_r;
  logic [IN_IDX_W-1:0]     idx_r;
  logic signed [SMP_W-1:0] smp_r;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;

  logic signed [SMP_W-1:0] mem [STORE_DEPTH];
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;

  // Update decision.
  logic [CMP_W-1:0] idx_ext, cnt_ext;
  always_comb begin
    idx_ext    = CMP_W'(idx_r);
    cnt_ext    = CMP_W'(count_r);
    wr_en      = 1'b0;
    wr_addr    = ADDR_W'(count_r);
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (mode_r && count_r != '0) begin
      if (idx_ext != '0 && idx_ext <= cnt_ext) begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(idx_ext - CMP_W'(1));
      end else begin
        status_nxt = ST_BAD_INDEX;
      end
    end else if (count_r < CNT_W'(STORE_DEPTH)) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end else begin
      status_nxt = ST_FULL;
    end
  end

  // Pass engine: read pointer, then data, abs deviation, square, accumulate.
  // Sample and mean both lie in the signed 32-bit range, so the magnitude of
  // their difference fits 32 unsigned bits.
  logic                    pass_run_r, pass_var_r;
  logic [CNT_W-1:0]        ptr_r;
  logic                    v1_r, v2_r, v3_r;
  logic signed [SMP_W-1:0] rd_data_r;
  logic [SMP_W-1:0]        m_r;
  logic [VAR_W-1:0]        sq_r;
  logic signed [TOT_W-1:0] total_r;
  logic [ACC_W-1:0]        acc_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic signed [SMP_W:0]   diff;
  logic [2*SMP_W-1:0]      prod;
  logic                    issue;

  assign issue = pass_run_r && (ptr_r < count_r);
  assign diff  = {rd_data_r[SMP_W-1], rd_data_r} - {mean_r[MEAN_W-1], mean_r};
  assign prod  = m_r * m_r;
  assign stat.pass_done = pass_run_r && !issue && !v1_r && !v2_r && !v3_r;

  always_ff @(posedge clk) begin
    if (cmd.upd && wr_en) begin
      mem[wr_addr] <= smp_r;
    end
    if (issue) begin
      rd_data_r <= mem[ptr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pass_run_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      if (cmd.upd) begin
        count_r <= count_nxt;
      end
      if (cmd.pass_start) begin
        pass_run_r <= 1'b1;
      end else if (stat.pass_done) begin
        pass_run_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r && pass_var_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_entry_index;
      smp_r  <= in_sample;
    end
    if (cmd.upd) begin
      status_r <= status_nxt;
    end
    if (cmd.pass_start) begin
      pass_var_r <= cmd.pass_var;
      ptr_r      <= '0;
      if (cmd.pass_var) begin
        acc_r <= '0;
      end else begin
        total_r <= '0;
      end
    end else begin
      if (issue) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
      if (v1_r && !pass_var_r) begin
        total_r <= total_r + TOT_W'(rd_data_r);
      end
      if (v1_r) begin
        m_r <= diff[SMP_W] ? SMP_W'(-diff) : SMP_W'(diff);
      end
      if (v2_r) begin
        sq_r <= VAR_W'(prod);
      end
      if (v3_r) begin
        acc_r <= acc_r + ACC_W'(sq_r);
      end
    end
  end

  // Shared restoring divider, one quotient bit a cycle.
  logic                 div_run_r, tot_neg_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [REM_W-1:0]     rem_r, rem_try;
  logic [ACC_W-1:0]     dvd_r, quo_r;
  logic [TOT_W-1:0]     tot_abs;
  logic [TOT_W-1:0]     mean_q;
  logic [VAR_W-1:0]     var_q, var_r;
  logic                 q_bit;

  assign tot_abs = total_r[TOT_W-1] ? TOT_W'(-total_r) : TOT_W'(total_r);
  assign rem_try = {rem_r[REM_W-2:0], dvd_r[ACC_W-1]};
  assign q_bit   = (rem_try >= {1'b0, count_r});
  assign stat.div_done = div_run_r && (dcnt_r == '0);
  assign mean_q  = tot_neg_r ? -quo_r[TOT_W-1:0] : quo_r[TOT_W-1:0];
  assign var_q   = (quo_r[ACC_W-1:VAR_W] != '0) ? '1 : quo_r[VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_run_r <= 1'b1;
    end else if (stat.div_done) begin
      div_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= '0;
      if (cmd.div_var) begin
        dvd_r  <= acc_r;
        dcnt_r <= DCNT_W'(ACC_W);
      end else begin
        dvd_r     <= {tot_abs, {(ACC_W-TOT_W){1'b0}}};
        dcnt_r    <= DCNT_W'(TOT_W);
        tot_neg_r <= total_r[TOT_W-1];
      end
    end else if (div_run_r && dcnt_r != '0) begin
      rem_r  <= q_bit ? rem_try - {1'b0, count_r} : rem_try;
      quo_r  <= {quo_r[ACC_W-2:0], q_bit};
      dvd_r  <= {dvd_r[ACC_W-2:0], 1'b0};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (cmd.mean_take) begin
      mean_r <= MEAN_W'(mean_q);
    end
  end

  // Square root, two radicand bits a cycle.
  logic             sq_run_r;
  logic [VAR_W-1:0] x_r, res_r, bit_r, rb;

  assign rb = res_r + bit_r;
  assign stat.sqrt_done = sq_run_r && (bit_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_run_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_run_r <= 1'b1;
    end else if (stat.sqrt_done) begin
      sq_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      var_r <= var_q;
      x_r   <= var_q;
      res_r <= '0;
      bit_r <= SQ_BIT_INIT;
    end else if (sq_run_r && bit_r != '0) begin
      if (x_r >= rb) begin
        x_r   <= x_r - rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stored_count <= OUT_CNT_W'(count_r);
      out_status       <= status_r;
      if (count_r == '0) begin
        out_sample_total    <= '0;
        out_sample_mean     <= '0;
        out_sample_variance <= '0;
        out_std_deviation   <= '0;
      end else begin
        out_sample_total    <= total_r;
        out_sample_mean     <= mean_r;
        out_sample_variance <= var_r;
        out_std_deviation   <= SD_W'(res_r);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("sample count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_run_r |-> ptr_r <= count_r)
    else $error("pass pointer beyond held samples");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_run_r && count_r != '0 |-> rem_r < {1'b0, count_r})
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ hdl/sample_set_mean_variance_stddev.sv @@
// Top level of the sample set statistics block: controller, datapath and
// the channel interfaces. Depends on ssmv_pkg, ssmv_if, ssmv_ctrl, ssmv_dp.
//
// Usage: each item on in_ch either appends a signed Q16.16 sample or
// overwrites the sample at a 1-based entry_index. For every item one result
// appears on out_ch: total, mean, population variance (Q32.32), standard
// deviation (Q16.16), the count now held and a status (ok, store full,
// index out of range).
// For N held samples (N at most 64) a result takes two passes over the
// sample store, a 38-step mean divide, a 71-step variance divide and a
// 32-step square root. One item is worked on at a time; in_ch.ready is
// high only while the block is idle, so a new item is taken only once the
// result of the last one has been loaded into the output register.
// A finished result waits in an output register, so the next item can be
// taken while it is still unread; if it is still unread when the next
// result is ready, the block holds until out_ch.ready.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; no clearing pass is needed.
`default_nettype none

module sample_set_mean_variance_stddev import ssmv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ssmv_in_if.sink      in_ch,
  ssmv_out_if.source   out_ch
);

  ssmv_cmd_t  cmd;
  ssmv_stat_t stat;

  ssmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssmv_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_mode             (in_ch.mode),
    .in_entry_index      (in_ch.entry_index),
    .in_sample           (in_ch.sample),
    .out_sample_total    (out_ch.sample_total),
    .out_sample_mean     (out_ch.sample_mean),
    .out_sample_variance (out_ch.sample_variance),
    .out_std_deviation   (out_ch.std_deviation),
    .out_stored_count    (out_ch.stored_count),
    .out_status          (out_ch.status)
  );

endmodule

`default_nettype wire

@@ test/tb_ssmv_scoreboard.sv @@
// Scoreboard class for the sample set statistics testbench: keeps its own
// copy of the sample store and predicts each result. Depends on ssmv_pkg.
`timescale 1ns / 1ps

class ssmv_stats_board;
  typedef struct packed {
    logic signed [ssmv_pkg::TOT_W-1:0]  total;
    logic signed [ssmv_pkg::MEAN_W-1:0] mean;
    logic [ssmv_pkg::VAR_W-1:0]         variance;
    logic [ssmv_pkg::SD_W-1:0]          stddev;
    logic [ssmv_pkg::OUT_CNT_W-1:0]     count;
    logic [ssmv_pkg::STATUS_W-1:0]      status;
  } stats_t;

  logic signed [31:0] held [ssmv_pkg::STORE_DEPTH];
  int unsigned held_count;
  stats_t pending_stats[$];
  int error_count;

  function new();
    held_count  = 0;
    error_count = 0;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rest;
    root = 0;
    rest = v;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function void note_item(logic mode, logic [6:0] idx, logic signed [31:0] smp);
    stats_t      s;
    longint      sum;
    longint      avg;
    longint      diff;
    logic [127:0] sq_sum;
    logic [127:0] quot;
    s = '0;
    s.status = ssmv_pkg::ST_OK;
    if (mode && held_count != 0) begin
      if (idx >= 1 && idx <= held_count) held[idx-1] = smp;
      else s.status = ssmv_pkg::ST_BAD_INDEX;
    end else if (held_count < ssmv_pkg::STORE_DEPTH) begin
      held[held_count] = smp;
      held_count++;
    end else begin
      s.status = ssmv_pkg::ST_FULL;
    end
    if (held_count != 0) begin
      sum = 0;
      foreach (held[i]) if (i < held_count) sum += held[i];
      // SystemVerilog signed division truncates toward zero, as required.
      avg = sum / longint'(held_count);
      sq_sum = 0;
      foreach (held[i]) if (i < held_count) begin
        diff = held[i] - avg;
        if (diff < 0) diff = -diff;
        sq_sum += 128'(diff) * 128'(diff);
      end
      quot = sq_sum / 128'(held_count);
      s.variance = (quot[127:64] != 0) ? '1 : quot[63:0];
      s.total    = sum[37:0];
      s.mean     = avg[31:0];
      s.stddev   = 32'(floor_sqrt(s.variance));
    end
    s.count = held_count[6:0];
    pending_stats.push_back(s);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task check_result(stats_t got);
    stats_t exp;
    if (pending_stats.size() == 0) begin
      report("result with no item outstanding");
      return;
    end
    exp = pending_stats.pop_front();
    if (got.total !== exp.total)
      report($sformatf("total %0d, expected %0d", got.total, exp.total));
    if (got.mean !== exp.mean)
      report($sformatf("mean %0d, expected %0d", got.mean, exp.mean));
    if (got.variance !== exp.variance)
      report($sformatf("variance %0h, expected %0h", got.variance, exp.variance));
    if (got.stddev !== exp.stddev)
      report($sformatf("stddev %0h, expected %0h", got.stddev, exp.stddev));
    if (got.count !== exp.count)
      report($sformatf("count %0d, expected %0d", got.count, exp.count));
    if (got.status !== exp.status)
      report($sformatf("status %0d, expected %0d", got.status, exp.status));
  endtask
endclass

@@ test/tb_sample_set_mean_variance_stddev.sv @@
// Testbench top for the sample set statistics block: drives append and
// overwrite items, checks every result. Depends on ssmv_pkg, ssmv_if and
// the scoreboard class file.
`timescale 1ns / 1ps

module tb_sample_set_mean_variance_stddev;
  import ssmv_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 20000;

  logic clk;
  logic rst_n;
  bit   quiet_phase;
  bit   long_hold;
  bit   feeding_done;
  int   idle_cycles = 0;

  ssmv_in_if  in_ch();
  ssmv_out_if out_ch();
  ssmv_stats_board board;

  sample_set_mean_variance_stddev u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(logic mode, logic [6:0] idx, logic signed [31:0] smp);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.entry_index <= idx;
    in_ch.sample      <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(mode, idx, smp);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom);
    endcase
  endfunction

  // Sender: directed corner cases, then random filling and rewriting.
  initial begin
    int n;
    logic [6:0] idx;
    board = new();
    in_ch.valid <= 1'b0;
    in_ch.mode <= 1'b0;
    in_ch.entry_index <= '0;
    in_ch.sample <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Overwrite on an empty set acts as an append.
    send_item(1'b1, 7'd5, 32'sh7fff_ffff);
    send_item(1'b0, 7'd0, 32'sh8000_0000);
    send_item(1'b1, 7'd0, 32'sd1);
    send_item(1'b1, 7'd3, 32'sd1);
    send_item(1'b1, 7'd127, 32'sd1);
    send_item(1'b1, 7'd2, 32'sh7fff_ffff);
    send_item(1'b1, 7'd1, 32'sh8000_0000);
    send_item(1'b0, 7'd127, -32'sd1);
    // Fill the store to the top, try one append too many, then overwrite entry 64 and one past it.
    n = 0;
    while (board.held_count < STORE_DEPTH) begin
      send_item(1'b0, 7'(n), (n % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
      n++;
    end
    send_item(1'b0, 7'd64, 32'sd5);
    send_item(1'b1, 7'd64, 32'sd0);
    send_item(1'b1, 7'd65, 32'sd0);
    long_hold = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - 200) quiet_phase = 1'b1;
      if (k == 30) long_hold = 1'b0;
      // The store stays full from here on, as only reset empties it: appends are
      // refused as full, and most items rewrite an entry.
      if ($urandom_range(0, 9) < 7) idx = 7'($urandom_range(1, board.held_count));
      else idx = 7'($urandom_range(0, 127));
      send_item($urandom_range(0, 3) != 0, idx, pick_sample());
    end
    in_ch.valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // Receiver: random hold-offs, one long one while the sender keeps pushing.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.sample_total, out_ch.sample_mean,
                          out_ch.sample_variance, out_ch.std_deviation,
                          out_ch.stored_count, out_ch.status});
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    wait (feeding_done);
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.error_count == 0 && board.pending_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
